// File: hw/rtl/hfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants for the report frame checker.
// ----------------------------------------------------------------------------
package hfc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CodeW    = 3;

  localparam logic [CountW-1:0] CountSat      = 9'd256;
  localparam logic [CountW-1:0] MaxSizedIndex = 9'd254;
  localparam logic [CountW-1:0] FrameOverhead = 9'd7;

  localparam logic [CountW-1:0] IdxSyncFirst  = 9'd1;
  localparam logic [CountW-1:0] IdxSyncSecond = 9'd2;
  localparam logic [CountW-1:0] IdxVersion    = 9'd3;
  localparam logic [CountW-1:0] IdxCommand    = 9'd4;
  localparam logic [CountW-1:0] IdxLength     = 9'd5;

  localparam logic [ByteW-1:0] RstSyncFirst  = 8'h55;
  localparam logic [ByteW-1:0] RstSyncSecond = 8'hAA;
  localparam logic [ByteW-1:0] RstVersion    = 8'h01;
  localparam logic [ByteW-1:0] RstMaxCommand = 8'd10;

  typedef enum logic [CfgIdxW-1:0] {
    RegSyncFirst  = 4'd0,
    RegSyncSecond = 4'd1,
    RegVersion    = 4'd2,
    RegMaxCommand = 4'd3
  } reg_idx_e;

  typedef enum logic [CodeW-1:0] {
    ErrNone     = 3'd0,
    ErrSize     = 3'd1,
    ErrHeader   = 3'd2,
    ErrCommand  = 3'd3,
    ErrChecksum = 3'd4
  } err_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] version_value;
    logic [ByteW-1:0] max_command;
  } cfg_t;

  typedef struct packed {
    logic            frame_ok;
    logic [CodeW-1:0] error_code;
  } result_t;

endpackage

// File: hw/rtl/hfc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_cfg_regs
// Configuration register file holding the expected header values.
// ----------------------------------------------------------------------------
module hfc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [hfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hfc_pkg::ByteW-1:0]    cfg_data_i,
  output hfc_pkg::cfg_t                cfg_o
);

  hfc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= hfc_pkg::RstSyncFirst;
      cfg_q.sync_second   <= hfc_pkg::RstSyncSecond;
      cfg_q.version_value <= hfc_pkg::RstVersion;
      cfg_q.max_command   <= hfc_pkg::RstMaxCommand;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hfc_pkg::RegSyncFirst:  cfg_q.sync_first    <= cfg_data_i;
        hfc_pkg::RegSyncSecond: cfg_q.sync_second   <= cfg_data_i;
        hfc_pkg::RegVersion:    cfg_q.version_value <= cfg_data_i;
        hfc_pkg::RegMaxCommand: cfg_q.max_command   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/hfc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_check
// Per-frame state and the size, header, command and checksum checks.
// ----------------------------------------------------------------------------
module hfc_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hfc_pkg::cfg_t             cfg_i,
  input  logic                      step_i,
  input  logic [hfc_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_byte_i,
  output hfc_pkg::result_t          result_o
);

  logic [hfc_pkg::CountW-1:0] count_q, count_d;
  logic [hfc_pkg::ByteW-1:0]  len_q, len_d;
  logic                       hdr_good_q, hdr_good_d;
  logic                       cmd_good_q, cmd_good_d;
  logic [hfc_pkg::ByteW-1:0]  sum_q, sum_d;

  logic                       hdr_now, cmd_now, size_bad;
  logic [hfc_pkg::ByteW-1:0]  len_now;
  hfc_pkg::err_e              code;

  always_comb begin
    hdr_now = hdr_good_q;
    cmd_now = cmd_good_q;
    len_now = len_q;
    if ((count_q == hfc_pkg::IdxSyncFirst) && (data_byte_i != cfg_i.sync_first)) begin
      hdr_now = 1'b0;
    end
    if ((count_q == hfc_pkg::IdxSyncSecond) && (data_byte_i != cfg_i.sync_second)) begin
      hdr_now = 1'b0;
    end
    if ((count_q == hfc_pkg::IdxVersion) && (data_byte_i != cfg_i.version_value)) begin
      hdr_now = 1'b0;
    end
    if ((count_q == hfc_pkg::IdxCommand) && (data_byte_i > cfg_i.max_command)) begin
      cmd_now = 1'b0;
    end
    if (count_q == hfc_pkg::IdxLength) begin
      len_now = data_byte_i;
    end

    size_bad = (count_q > hfc_pkg::MaxSizedIndex) ||
               ((count_q + 9'd1) != ({1'b0, len_now} + hfc_pkg::FrameOverhead));

    if (size_bad) begin
      code = hfc_pkg::ErrSize;
    end else if (!hdr_now) begin
      code = hfc_pkg::ErrHeader;
    end else if (!cmd_now) begin
      code = hfc_pkg::ErrCommand;
    end else if (data_byte_i != sum_q) begin
      code = hfc_pkg::ErrChecksum;
    end else begin
      code = hfc_pkg::ErrNone;
    end

    result_o.frame_ok   = (code == hfc_pkg::ErrNone);
    result_o.error_code = code;
  end

  always_comb begin
    count_d    = count_q;
    len_d      = len_q;
    hdr_good_d = hdr_good_q;
    cmd_good_d = cmd_good_q;
    sum_d      = sum_q;
    if (step_i) begin
      if (last_byte_i) begin
        count_d    = '0;
        len_d      = '0;
        hdr_good_d = 1'b1;
        cmd_good_d = 1'b1;
        sum_d      = '0;
      end else begin
        len_d      = len_now;
        hdr_good_d = hdr_now;
        cmd_good_d = cmd_now;
        if (count_q != '0) begin
          sum_d = sum_q + data_byte_i;
        end
        if (count_q < hfc_pkg::CountSat) begin
          count_d = count_q + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      len_q      <= '0;
      hdr_good_q <= 1'b1;
      cmd_good_q <= 1'b1;
      sum_q      <= '0;
    end else begin
      count_q    <= count_d;
      len_q      <= len_d;
      hdr_good_q <= hdr_good_d;
      cmd_good_q <= cmd_good_d;
      sum_q      <= sum_d;
    end
  end

endmodule

// File: hw/rtl/hid_frame_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_frame_checker_top
// Checks received report frames byte by byte and reports one verdict per frame.
// ----------------------------------------------------------------------------
// Frame bytes enter on the input channel (data_byte_i, last_byte_i) with
// valid and ready. Each request lands in an input register, and the checks
// run combinationally between that register and the result register.
// Only a request marked last produces a result request on the output
// channel (frame_ok_o, error_code_o); the verdict enters the result register
// when the last byte steps out of the input register.
// One byte is accepted per cycle unless a last byte is held in the input
// register. While a result waits in the output register, bytes that are
// not last keep flowing; a second last byte waits in the input register
// until the receiver takes the pending result. Configuration writes carry
// a register index and data and are always accepted; indexes beyond the
// list are ignored. They are meant to be issued while no frame is in flight.
// Reset empties both registers, restores the register defaults and starts
// a new frame at byte index 0.
// ----------------------------------------------------------------------------
module hid_frame_checker_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hfc_pkg::ByteW-1:0]           data_byte_i,
  input  logic                                last_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                frame_ok_o,
  output logic [hfc_pkg::CodeW-1:0]           error_code_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hfc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [hfc_pkg::ByteW-1:0]           cfg_data_i
);

  hfc_pkg::cfg_t              cfg;
  hfc_pkg::result_t           result;
  hfc_pkg::result_t           out_q;

  logic                       in_vld_q;
  logic [hfc_pkg::ByteW-1:0]  in_byte_q;
  logic                       in_last_q;
  logic                       out_vld_q;
  logic                       out_free;
  logic                       step;

  assign cfg_ready_o = 1'b1;

  hfc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && (!in_last_q || out_free);
  assign in_ready_o = !in_vld_q || step;

  hfc_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign frame_ok_o   = out_q.frame_ok;
  assign error_code_o = out_q.error_code;

endmodule

// File: dv/hfc_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfc_verdict_checker
// Tracks report frames on the byte channel and checks every frame verdict.
// ----------------------------------------------------------------------------
// Each accepted byte request advances a private copy of the frame state and
// of the four match registers. The last byte of a frame yields the expected
// verdict, which waits in order until the next result request is accepted.
// ----------------------------------------------------------------------------
module hfc_verdict_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [hfc_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         last_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         frame_ok_i,
  input  logic [hfc_pkg::CodeW-1:0]    error_code_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [hfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hfc_pkg::ByteW-1:0]    cfg_data_i,
  output int unsigned                  pending_o,
  output int unsigned                  fail_count_o
);

  hfc_pkg::cfg_t              match_regs;
  logic [hfc_pkg::CountW-1:0] byte_idx;
  logic [hfc_pkg::ByteW-1:0]  len_seen;
  logic [hfc_pkg::ByteW-1:0]  sum_seen;
  logic                       header_ok;
  logic                       command_ok;
  hfc_pkg::result_t           verdict_q[$];
  hfc_pkg::result_t           want;
  int unsigned                fails = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] frame verdict: %s", $time, msg);
    fails++;
  endtask

  task automatic clear_frame();
    byte_idx   = '0;
    len_seen   = '0;
    sum_seen   = '0;
    header_ok  = 1'b1;
    command_ok = 1'b1;
  endtask

  task automatic predict_verdict(input logic [hfc_pkg::ByteW-1:0] b, input logic last);
    logic [hfc_pkg::CountW-1:0] size_need;
    hfc_pkg::err_e              code;
    hfc_pkg::result_t           verdict;
    case (byte_idx)
      hfc_pkg::IdxSyncFirst:  if (b != match_regs.sync_first) header_ok = 1'b0;
      hfc_pkg::IdxSyncSecond: if (b != match_regs.sync_second) header_ok = 1'b0;
      hfc_pkg::IdxVersion:    if (b != match_regs.version_value) header_ok = 1'b0;
      hfc_pkg::IdxCommand:    if (b > match_regs.max_command) command_ok = 1'b0;
      hfc_pkg::IdxLength:     len_seen = b;
      default: ;
    endcase
    if (!last) begin
      if (byte_idx != '0) sum_seen = sum_seen + b;
      if (byte_idx < hfc_pkg::CountSat) byte_idx = byte_idx + 1'b1;
    end else begin
      size_need = {1'b0, len_seen} + hfc_pkg::FrameOverhead;
      if (byte_idx > hfc_pkg::MaxSizedIndex || byte_idx + 1'b1 != size_need) begin
        code = hfc_pkg::ErrSize;
      end else if (!header_ok) begin
        code = hfc_pkg::ErrHeader;
      end else if (!command_ok) begin
        code = hfc_pkg::ErrCommand;
      end else if (b != sum_seen) begin
        code = hfc_pkg::ErrChecksum;
      end else begin
        code = hfc_pkg::ErrNone;
      end
      verdict.frame_ok   = (code == hfc_pkg::ErrNone);
      verdict.error_code = code;
      verdict_q.push_back(verdict);
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_regs.sync_first    = hfc_pkg::RstSyncFirst;
      match_regs.sync_second   = hfc_pkg::RstSyncSecond;
      match_regs.version_value = hfc_pkg::RstVersion;
      match_regs.max_command   = hfc_pkg::RstMaxCommand;
      clear_frame();
      verdict_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          hfc_pkg::RegSyncFirst:  match_regs.sync_first    = cfg_data_i;
          hfc_pkg::RegSyncSecond: match_regs.sync_second   = cfg_data_i;
          hfc_pkg::RegVersion:    match_regs.version_value = cfg_data_i;
          hfc_pkg::RegMaxCommand: match_regs.max_command   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_verdict(data_byte_i, last_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result request (ok %0d, code %0d) with no frame pending",
                                    frame_ok_i, error_code_i));
        end else begin
          want = verdict_q.pop_front();
          if (frame_ok_i !== want.frame_ok)
            report_mismatch($sformatf("frame_ok %0d, expected %0d", frame_ok_i, want.frame_ok));
          if (error_code_i !== want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      error_code_i, want.error_code));
        end
      end
    end
    pending_o    <= verdict_q.size();
    fail_count_o <= fails;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the report frame checker.
// ----------------------------------------------------------------------------
// A short directed run covers the one-byte frame, the largest legal command
// and the command, checksum and header failures. Random phases then send
// mostly well-formed frames with random content, mixed with size, header,
// command and checksum faults, truncated frames, noise and over-long frames,
// under several match register settings including all zeros and all ones.
// Both sides idle in random bursts; the final phase runs without idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ByteW         = hfc_pkg::ByteW;
  localparam int unsigned CfgIdxW       = hfc_pkg::CfgIdxW;
  localparam int unsigned CodeW         = hfc_pkg::CodeW;
  localparam int unsigned PhaseCount    = 6;
  localparam int unsigned PhaseBytes    = 325;
  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned FirstSpareIdx = hfc_pkg::RegMaxCommand + 1;
  localparam int unsigned LastIdx       = (1 << CfgIdxW) - 1;
  localparam int unsigned GapPct   [PhaseCount] = '{30, 0, 60, 15, 40, 0};
  localparam int unsigned StallPct [PhaseCount] = '{25, 50, 0, 15, 40, 0};

  typedef enum int unsigned {
    FrGood,
    FrBadSize,
    FrBadHeader,
    FrBadCommand,
    FrBadChecksum,
    FrShort,
    FrNoise,
    FrLong
  } frame_kind_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic [ByteW-1:0]   data_byte = '0;
  logic               last_byte = 1'b0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;
  logic               in_ready;
  logic               out_valid;
  logic               frame_ok;
  logic [CodeW-1:0]   error_code;
  logic               cfg_ready;
  int unsigned        pending;
  int unsigned        failures;

  hfc_pkg::cfg_t    live_cfg;
  logic [ByteW-1:0] frame_q[$];
  int unsigned      sent_bytes = 0;
  int unsigned      gap_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      stall_left = 0;
  int unsigned      cycles = 0;
  int unsigned      phase;
  int unsigned      frame_no;
  frame_kind_e      kind;

  always #2 clk = ~clk;

  hid_frame_checker_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .last_byte_i  (last_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .frame_ok_o   (frame_ok),
    .error_code_o (error_code),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  hfc_verdict_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .data_byte_i  (data_byte),
    .last_byte_i  (last_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .frame_ok_i   (frame_ok),
    .error_code_i (error_code),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (failures)
  );

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[hid_frame_checker_top] ERROR");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1);
    sent_bytes += frame_q.size();
  endtask

  // Holds the byte channel idle until every verdict has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input hfc_pkg::cfg_t c);
    write_reg(hfc_pkg::RegSyncFirst, c.sync_first);
    write_reg(hfc_pkg::RegSyncSecond, c.sync_second);
    write_reg(hfc_pkg::RegVersion, c.version_value);
    write_reg(hfc_pkg::RegMaxCommand, c.max_command);
    write_reg(CfgIdxW'($urandom_range(FirstSpareIdx, LastIdx)), ByteW'($urandom));
    cfg_valid <= 1'b0;
    live_cfg = c;
    @(posedge clk);
  endtask

  function automatic frame_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return FrGood;
    if (r < 55) return FrBadSize;
    if (r < 65) return FrBadHeader;
    if (r < 73) return FrBadCommand;
    if (r < 83) return FrBadChecksum;
    if (r < 90) return FrShort;
    if (r < 99) return FrNoise;
    return FrLong;
  endfunction

  function automatic int unsigned pick_plen();
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic build_frame(input frame_kind_e fk, input int unsigned plen);
    int unsigned      len_field;
    int unsigned      k;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] sum;
    logic             bad_cmd;
    logic             bad_hdr;
    logic             bad_sum;
    bad_cmd = (fk == FrBadCommand) || (fk == FrBadHeader && $urandom_range(0, 1));
    if (live_cfg.max_command == '1) bad_cmd = 1'b0;
    bad_hdr = (fk == FrBadHeader) || (fk == FrBadSize && $urandom_range(0, 1));
    bad_sum = (fk == FrBadChecksum) ||
              ((fk == FrBadHeader || fk == FrBadCommand) && $urandom_range(0, 1));
    if (bad_cmd) begin
      cmd = ByteW'($urandom_range(live_cfg.max_command + 1, 255));
    end else begin
      case ($urandom_range(0, 3))
        0: cmd = '0;
        1: cmd = live_cfg.max_command;
        default: cmd = ByteW'($urandom_range(0, live_cfg.max_command));
      endcase
    end
    len_field = plen;
    if (fk == FrBadSize) begin
      case ($urandom_range(0, 2))
        0: len_field = plen + 1;
        1: len_field = (plen == 0) ? 255 : plen - 1;
        default: len_field = (plen + $urandom_range(1, 255)) % 256;
      endcase
    end else if (fk == FrLong && plen > 255) begin
      len_field = $urandom_range(0, 255);
    end
    frame_q = {};
    frame_q.push_back(ByteW'($urandom));
    frame_q.push_back(live_cfg.sync_first);
    frame_q.push_back(live_cfg.sync_second);
    frame_q.push_back(live_cfg.version_value);
    frame_q.push_back(cmd);
    frame_q.push_back(ByteW'(len_field));
    repeat (plen) frame_q.push_back(ByteW'($urandom));
    if (bad_hdr) begin
      k = $urandom_range(1, 3);
      frame_q[k] = frame_q[k] ^ ByteW'($urandom_range(1, 255));
    end
    sum = '0;
    for (k = 1; k < frame_q.size(); k++) sum = sum + frame_q[k];
    if (bad_sum) sum = sum ^ ByteW'($urandom_range(1, 255));
    frame_q.push_back(sum);
    if (fk == FrShort) begin
      k = $urandom_range(1, 6);
      while (frame_q.size() > k) void'(frame_q.pop_back());
    end else if (fk == FrNoise) begin
      frame_q = {};
      repeat ($urandom_range(1, 20)) frame_q.push_back(ByteW'($urandom));
    end
  endtask

  function automatic hfc_pkg::cfg_t phase_cfg(input int unsigned p);
    case (p)
      1: return '0;
      2: return '1;
      default: return hfc_pkg::cfg_t'($urandom);
    endcase
  endfunction

  initial begin
    live_cfg.sync_first    = hfc_pkg::RstSyncFirst;
    live_cfg.sync_second   = hfc_pkg::RstSyncSecond;
    live_cfg.version_value = hfc_pkg::RstVersion;
    live_cfg.max_command   = hfc_pkg::RstMaxCommand;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = GapPct[0];
    stall_pct = StallPct[0];
    send_byte('1, 1'b1);
    frame_q = '{8'h00, live_cfg.sync_first, live_cfg.sync_second, live_cfg.version_value,
                live_cfg.max_command, 8'h00};
    frame_q.push_back(live_cfg.sync_first + live_cfg.sync_second + live_cfg.version_value +
                      live_cfg.max_command);
    send_frame();
    build_frame(FrBadCommand, 0);
    send_frame();
    build_frame(FrBadChecksum, 0);
    send_frame();
    build_frame(FrBadHeader, 0);
    send_frame();

    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase != 0) begin
        drain();
        program_regs(phase_cfg(phase));
      end
      gap_pct   = GapPct[phase];
      stall_pct = StallPct[phase];
      frame_no  = 0;
      while (sent_bytes < (phase + 1) * PhaseBytes) begin
        if (phase == 0 && frame_no == 2) begin
          build_frame(FrLong, 248);
        end else if (phase == 2 && frame_no == 2) begin
          build_frame(FrLong, 300);
        end else begin
          kind = pick_kind();
          build_frame(kind, (kind == FrLong) ? $urandom_range(248, 300) : pick_plen());
        end
        if ((phase == 1 && frame_no == 5) || $urandom_range(0, 99) < 3) drain();
        send_frame();
        frame_no++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("[hid_frame_checker_top] OK");
    end else begin
      $display("[hid_frame_checker_top] ERROR");
    end
    $finish;
  end

endmodule
